// File: sv/lfs_pkg.sv
// Shared types and constants of the line follow steering unit.
package lfs_pkg;

  // Sequencing strobes that drive a serial unit.
  typedef struct packed {
    logic load;
    logic step;
  } lfs_seq_t;

  // Configuration register indexes.
  localparam logic [3:0] REG_PID_MODE    = 4'd0;
  localparam logic [3:0] REG_GAIN_P      = 4'd1;
  localparam logic [3:0] REG_GAIN_I      = 4'd2;
  localparam logic [3:0] REG_GAIN_D      = 4'd3;
  localparam logic [3:0] REG_DEAD_BAND   = 4'd4;
  localparam logic [3:0] REG_STEER_LIMIT = 4'd5;
  localparam logic [3:0] REG_BASE_SPEED  = 4'd6;
  localparam logic [3:0] REG_RAMP_CYCLES = 4'd7;

  // Slow-down span: the base factor reaches zero at this offset (20.0 in Q8.8).
  localparam logic [12:0] SLOW_SPAN = 13'd5120;
  localparam logic [11:0] SLOW_HALF = 12'd2560;

  // ceil(2^22 / 5): exact reciprocal for dividends below 2^22.
  localparam logic [19:0] RECIP_FIFTH = 20'd838861;
  localparam int          RECIP_SHIFT = 22;

  // Index of the last serial step of the multiplier and divider.
  localparam logic [3:0] LAST_STEP = 4'd15;

endpackage

// File: sv/lfs_mul_lane.sv
// Bit-serial signed-by-unsigned multiplier lane, one multiplier bit per cycle.
module lfs_mul_lane import lfs_pkg::*; (
  input  logic               clk,
  input  lfs_seq_t           ctl,
  input  logic signed [21:0] mcand_i,
  input  logic        [15:0] mplier_i,
  output logic signed [38:0] prod_o
);

  logic signed [21:0] mcand_r;
  logic        [15:0] mplier_r;
  logic signed [22:0] phi_r;
  logic        [15:0] plo_r;
  logic signed [23:0] addend;
  logic signed [23:0] psum;

  always_comb begin
    addend = mplier_r[0] ? {{2{mcand_r[21]}}, mcand_r} : 24'sd0;
    psum   = {phi_r[22], phi_r} + addend;
  end

  // Add the selected multiple, then shift one bit into the low half.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mcand_r  <= mcand_i;
      mplier_r <= mplier_i;
      phi_r    <= '0;
      plo_r    <= '0;
    end else if (ctl.step) begin
      phi_r    <= psum[23:1];
      plo_r    <= {psum[0], plo_r[15:1]};
      mplier_r <= {1'b0, mplier_r[15:1]};
    end
  end

  assign prod_o = {phi_r, plo_r};

endmodule

// File: sv/lfs_div_unit.sv
// Restoring divider, one quotient bit per cycle, 16-bit quotient.
module lfs_div_unit import lfs_pkg::*; (
  input  logic        clk,
  input  lfs_seq_t    ctl,
  input  logic [36:0] num_i,
  input  logic [20:0] den_i,
  output logic [15:0] quo_o
);

  logic [20:0] rem_r;
  logic [15:0] low_r;
  logic [20:0] den_r;
  logic [21:0] trial;
  logic [21:0] diff;
  logic        ge;

  always_comb begin
    trial = {rem_r, low_r[15]};
    ge    = trial >= {1'b0, den_r};
    diff  = trial - {1'b0, den_r};
  end

  // Low register carries the dividend bits out and the quotient bits in.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem_r <= num_i[36:16];
      low_r <= num_i[15:0];
      den_r <= den_i;
    end else if (ctl.step) begin
      rem_r <= ge ? diff[20:0] : trial[20:0];
      low_r <= {low_r[14:0], ge};
    end
  end

  assign quo_o = low_r;

endmodule

// File: sv/lfs_wheel_mix.sv
// Wheel target mixing: direction, magnitude scaling by 7/5 and 7/10, saturation.
module lfs_wheel_mix import lfs_pkg::*; (
  input  logic               clk,
  input  logic               en_i,
  input  logic        [15:0] base_i,
  input  logic signed [15:0] steer_i,
  output logic               l_rev_o,
  output logic        [15:0] l_spd_o,
  output logic               r_rev_o,
  output logic        [15:0] r_spd_o
);

  logic signed [17:0] spe_l;
  logic signed [17:0] spe_r;
  logic        [16:0] abs_l;
  logic        [16:0] abs_r;
  logic        [18:0] xl_nxt;
  logic        [18:0] xr_nxt;
  logic        [18:0] xl_r;
  logic        [18:0] xr_r;
  logic               lrev_r;
  logic               rrev_r;
  logic        [38:0] pl;
  logic        [38:0] pr;
  logic        [16:0] ql;
  logic        [16:0] qr;

  always_comb begin
    spe_l  = $signed({2'b00, base_i}) + {{2{steer_i[15]}}, steer_i};
    spe_r  = $signed({2'b00, base_i}) - {{2{steer_i[15]}}, steer_i};
    abs_l  = spe_l[17] ? 17'(-spe_l) : spe_l[16:0];
    abs_r  = spe_r[17] ? 17'(-spe_r) : spe_r[16:0];
    // Round to nearest: add half the divisor before the constant divide.
    xl_nxt = 19'(19'(abs_l) * 19'd7 + 19'd2);
    xr_nxt = 19'(19'(abs_r) * 19'd7 + 19'd5);
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      xl_r   <= xl_nxt;
      xr_r   <= xr_nxt;
      lrev_r <= spe_l[17];
      rrev_r <= spe_r[17];
    end
  end

  // Divide by 5 through the reciprocal; by 10 as a halving first.
  always_comb begin
    pl = 39'(xl_r) * 39'(RECIP_FIFTH);
    pr = 39'({1'b0, xr_r[18:1]}) * 39'(RECIP_FIFTH);
    ql = pl[RECIP_SHIFT+16:RECIP_SHIFT];
    qr = pr[RECIP_SHIFT+16:RECIP_SHIFT];
  end

  assign l_rev_o = lrev_r;
  assign r_rev_o = rrev_r;
  assign l_spd_o = ql[16] ? 16'hFFFF : ql[15:0];
  assign r_spd_o = qr[16] ? 16'hFFFF : qr[15:0];

endmodule

// File: sv/line_follow_steering_unit.sv
// Top level of the line follow steering unit: PID steering and wheel targets.
// One transaction in, one result out. Each accepted offset is held while the
// line is lost (all_white high), dead-banded, and run through a position or
// incremental PID whose output is clamped to +-steer_limit. The base speed is
// scaled by the curve slow-down factor and the start ramp, then mixed with the
// steering value into two wheel targets. From acceptance to out_valid a
// transaction passes through the preparation states PREP1 and PREP2, the
// bit-serial multiplier lanes (one gain bit per cycle), a divider load state,
// the restoring divider that forms the rounded base speed (one quotient bit
// per cycle, the PID sums are finished alongside), and the wheel mixing
// states FIN1 and FIN2. in_ready is high only while no transaction is in
// flight; a finished result waits in the output register, so the next
// transaction may start while it is not yet taken. Configuration writes are
// taken every cycle and belong in idle periods only.
module line_follow_steering_unit import lfs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input transactions
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_line_error,
  input  logic               in_all_white,
  // result transactions
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_left_reverse,
  output logic        [15:0] out_left_speed,
  output logic               out_right_reverse,
  output logic        [15:0] out_right_speed,
  output logic signed [15:0] out_steer_value,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [3:0]  cfg_index,
  input  logic        [15:0] cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP1 = 3'd1;
  localparam logic [2:0] S_PREP2 = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DIVLD = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FIN1  = 3'd6;
  localparam logic [2:0] S_FIN2  = 3'd7;

  // Configuration registers.
  logic        pid_mode_r;
  logic [15:0] gain_p_r;
  logic [15:0] gain_i_r;
  logic [15:0] gain_d_r;
  logic [14:0] dead_band_r;
  logic [14:0] steer_limit_r;
  logic [14:0] base_speed_r;
  logic [7:0]  ramp_cycles_r;

  // Sequencer.
  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic [3:0] cnt_r;
  logic [3:0] cnt_nxt;

  // Captured transaction.
  logic signed [15:0] err_in_r;
  logic               white_in_r;

  // Controller state.
  logic signed [15:0] held_r;
  logic signed [15:0] prev1_r;
  logic signed [15:0] prev2_r;
  logic signed [31:0] isum_r;
  logic signed [15:0] accum_r;
  logic        [7:0]  rcnt_r;

  // Per-transaction working registers.
  logic signed [15:0] e0_r;
  logic signed [18:0] xp_r;
  logic signed [18:0] yd_r;
  logic        [12:0] magb_r;
  logic        [7:0]  rcn_r;
  logic        [7:0]  rcd_r;
  logic signed [30:0] rp_r;
  logic signed [30:0] ri_r;
  logic signed [30:0] rd_r;
  logic signed [32:0] t_r;

  // Output register.
  logic               out_valid_r;
  logic               out_lrev_r;
  logic        [15:0] out_lspd_r;
  logic               out_rrev_r;
  logic        [15:0] out_rspd_r;
  logic signed [15:0] out_steer_r;

  // Configuration write decode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pid_mode_r    <= 1'b0;
      gain_p_r      <= 16'd0;
      gain_i_r      <= 16'd0;
      gain_d_r      <= 16'd0;
      dead_band_r   <= 15'd128;
      steer_limit_r <= 15'd1536;
      base_speed_r  <= 15'd3840;
      ramp_cycles_r <= 8'd50;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PID_MODE:    pid_mode_r    <= cfg_data[0];
        REG_GAIN_P:      gain_p_r      <= cfg_data;
        REG_GAIN_I:      gain_i_r      <= cfg_data;
        REG_GAIN_D:      gain_d_r      <= cfg_data;
        REG_DEAD_BAND:   dead_band_r   <= cfg_data[14:0];
        REG_STEER_LIMIT: steer_limit_r <= cfg_data[14:0];
        REG_BASE_SPEED:  base_speed_r  <= cfg_data[14:0];
        REG_RAMP_CYCLES: ramp_cycles_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);

  // Preparation: hold the offset while the line is lost, apply the dead band,
  // build the PID multiplicands, the slow-down factor and the ramp ratio.
  logic signed [15:0] held_nxt;
  logic        [16:0] held_abs;
  logic signed [15:0] e0_nxt;
  logic signed [18:0] d01;
  logic signed [18:0] d012;
  logic               ramp_on;

  always_comb begin
    held_nxt = white_in_r ? held_r : err_in_r;
    held_abs = held_nxt[15] ? 17'(-$signed({held_nxt[15], held_nxt}))
                            : {1'b0, held_nxt};
    e0_nxt   = (held_abs < {2'b00, dead_band_r}) ? 16'sd0 : held_nxt;
    d01      = 19'(e0_nxt) - 19'(prev1_r);
    d012     = 19'(e0_nxt) - 19'(prev1_r) - 19'(prev1_r) + 19'(prev2_r);
    ramp_on  = rcnt_r < ramp_cycles_r;
  end

  // Serial multiplier lanes: proportional, integral, derivative, base speed.
  lfs_seq_t           mul_ctl;
  lfs_seq_t           div_ctl;
  logic signed [38:0] prod_p;
  logic signed [38:0] prod_i;
  logic signed [38:0] prod_d;
  logic signed [38:0] prod_b;
  logic        [20:0] magb_ramp;

  assign mul_ctl.load = (state_r == S_PREP2);
  assign mul_ctl.step = (state_r == S_MUL);
  assign div_ctl.load = (state_r == S_DIVLD);
  assign div_ctl.step = (state_r == S_DIV);
  assign magb_ramp    = 21'(magb_r) * 21'(rcn_r);

  lfs_mul_lane u_lane_p (
    .clk      (clk),
    .ctl      (mul_ctl),
    .mcand_i  (22'(xp_r)),
    .mplier_i (gain_p_r),
    .prod_o   (prod_p)
  );

  lfs_mul_lane u_lane_i (
    .clk      (clk),
    .ctl      (mul_ctl),
    .mcand_i  (22'(e0_r)),
    .mplier_i (gain_i_r),
    .prod_o   (prod_i)
  );

  lfs_mul_lane u_lane_d (
    .clk      (clk),
    .ctl      (mul_ctl),
    .mcand_i  (22'(yd_r)),
    .mplier_i (gain_d_r),
    .prod_o   (prod_d)
  );

  lfs_mul_lane u_lane_b (
    .clk      (clk),
    .ctl      (mul_ctl),
    .mcand_i  ($signed({1'b0, magb_ramp})),
    .mplier_i ({1'b0, base_speed_r}),
    .prod_o   (prod_b)
  );

  // Base speed = round(base * slow * ramp_num / (5120 * ramp_den)).
  logic [20:0] div_den;
  logic [36:0] div_num;
  logic [15:0] base_quo;

  always_comb begin
    div_den = 21'(rcd_r) * 21'(SLOW_SPAN);
    div_num = prod_b[36:0] + 37'(37'(rcd_r) * 37'(SLOW_HALF));
  end

  lfs_div_unit u_div (
    .clk   (clk),
    .ctl   (div_ctl),
    .num_i (div_num),
    .den_i (div_den),
    .quo_o (base_quo)
  );

  // Round the gain products to Q8.8, halves toward +infinity.
  logic signed [38:0] rnd_p;
  logic signed [38:0] rnd_i;
  logic signed [38:0] rnd_d;
  logic signed [32:0] isum_add;
  logic signed [31:0] isum_sat;
  logic signed [32:0] t_nxt;
  logic signed [33:0] pid_sum;
  logic signed [33:0] lim_pos;
  logic signed [33:0] lim_neg;
  logic signed [15:0] accum_nxt;

  always_comb begin
    rnd_p    = prod_p + 39'sd128;
    rnd_i    = prod_i + 39'sd128;
    rnd_d    = prod_d + 39'sd128;
    isum_add = 33'(isum_r) + 33'(ri_r);
    // Saturate the running integral to the 32-bit signed range.
    if (isum_add[32] != isum_add[31]) begin
      isum_sat = isum_add[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      isum_sat = isum_add[31:0];
    end
    t_nxt    = 33'(rp_r) + 33'(rd_r) + (pid_mode_r ? 33'(accum_r) : 33'sd0);
    pid_sum  = 34'(t_r) + 34'(isum_r);
    lim_pos  = $signed({19'd0, steer_limit_r});
    lim_neg  = -lim_pos;
    if (pid_sum > lim_pos) begin
      accum_nxt = 16'(lim_pos);
    end else if (pid_sum < lim_neg) begin
      accum_nxt = 16'(lim_neg);
    end else begin
      accum_nxt = 16'(pid_sum);
    end
  end

  // Wheel mixing.
  logic        mix_lrev;
  logic [15:0] mix_lspd;
  logic        mix_rrev;
  logic [15:0] mix_rspd;

  lfs_wheel_mix u_mix (
    .clk     (clk),
    .en_i    (state_r == S_FIN1),
    .base_i  (base_quo),
    .steer_i (accum_r),
    .l_rev_o (mix_lrev),
    .l_spd_o (mix_lspd),
    .r_rev_o (mix_rrev),
    .r_spd_o (mix_rspd)
  );

  logic out_load;
  assign out_load = (state_r == S_FIN2) && (!out_valid_r || out_ready);

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_PREP1;
      end
      S_PREP1: state_nxt = S_PREP2;
      S_PREP2: begin
        state_nxt = S_MUL;
        cnt_nxt   = 4'd0;
      end
      S_MUL: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == LAST_STEP) state_nxt = S_DIVLD;
      end
      S_DIVLD: begin
        state_nxt = S_DIV;
        cnt_nxt   = 4'd0;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == LAST_STEP) state_nxt = S_FIN1;
      end
      S_FIN1: state_nxt = S_FIN2;
      S_FIN2: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 4'd0;
      out_valid_r <= 1'b0;
      held_r      <= 16'sd0;
      prev1_r     <= 16'sd0;
      prev2_r     <= 16'sd0;
      isum_r      <= 32'sd0;
      accum_r     <= 16'sd0;
      rcnt_r      <= 8'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;

      // Drop the result once taken; a new one replaces it on load.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (state_r == S_PREP1) begin
        held_r <= held_nxt;
        if (ramp_on) rcnt_r <= rcnt_r + 8'd1;
      end

      if (state_r == S_DIV && cnt_r == 4'd0) begin
        isum_r <= pid_mode_r ? 32'(ri_r) : isum_sat;
      end

      // Finish the PID: clamp, store and advance the error history.
      if (state_r == S_DIV && cnt_r == 4'd1) begin
        accum_r <= accum_nxt;
        prev2_r <= prev1_r;
        prev1_r <= e0_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      err_in_r   <= in_line_error;
      white_in_r <= in_all_white;
    end

    if (state_r == S_PREP1) begin
      e0_r   <= e0_nxt;
      xp_r   <= pid_mode_r ? d01 : 19'(e0_nxt);
      yd_r   <= pid_mode_r ? d012 : d01;
      magb_r <= (held_abs >= 17'(SLOW_SPAN)) ? 13'd0 : 13'(17'(SLOW_SPAN) - held_abs);
      rcn_r  <= ramp_on ? (rcnt_r + 8'd1) : 8'd1;
      rcd_r  <= ramp_on ? ramp_cycles_r : 8'd1;
    end

    if (state_r == S_DIVLD) begin
      rp_r <= rnd_p[38:8];
      ri_r <= rnd_i[38:8];
      rd_r <= rnd_d[38:8];
    end

    if (state_r == S_DIV && cnt_r == 4'd0) begin
      t_r <= t_nxt;
    end

    if (out_load) begin
      out_lrev_r  <= mix_lrev;
      out_lspd_r  <= mix_lspd;
      out_rrev_r  <= mix_rrev;
      out_rspd_r  <= mix_rspd;
      out_steer_r <= accum_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_reverse  = out_lrev_r;
  assign out_left_speed    = out_lspd_r;
  assign out_right_reverse = out_rrev_r;
  assign out_right_speed   = out_rspd_r;
  assign out_steer_value   = out_steer_r;

  // A transaction keeps the block busy for the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction was in flight");

  // The steering value just stored never leaves the clamp.
  a_steer_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && (cnt_r == 4'd2) |->
    (accum_r <= $signed({1'b0, steer_limit_r}))
    && (accum_r >= -$signed({1'b0, steer_limit_r})))
    else $error("steering value outside the limit");

  // A finished result waits in the last stage while the output is occupied.
  a_hold_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN2) && out_valid_r && !out_ready |=> (state_r == S_FIN2))
    else $error("result lost while output register full");

endmodule
